@@ src/bwtinv_pkg.sv @@
// Shared types and constants of the inverse BWT block.
// Depends on nothing; bwtinv_if and bwt_inverse_lf_walk use it by scoped names.
`default_nettype none

package bwtinv_pkg;

  localparam int unsigned BLOCK_SIZE_DEF = 4096;
  localparam int unsigned NSYM           = 256;
  localparam int unsigned SYM_W          = 8;
  localparam int unsigned SYM_IDX_W      = 9;   // counts 0..NSYM during the prefix sweep
  localparam int unsigned POS_W          = 12;
  localparam int unsigned PRI_W          = 12;
  localparam int unsigned STAT_W         = 2;

  // request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NODATA = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_PFX,
    S_WALK_A,
    S_WALK_B,
    S_WALK_C,
    S_RD,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

@@ src/bwtinv_if.sv @@
// Valid/ready channel interfaces: request words in, result words out.
// Depends on bwtinv_pkg for field widths.
`default_nettype none

interface bwtinv_in_if;
  logic                            valid;
  logic                            ready;
  logic                            req_type;
  logic [bwtinv_pkg::SYM_W-1:0]    symbol;
  logic                            end_of_block;
  logic [bwtinv_pkg::PRI_W-1:0]    primary_index;

  modport source (output valid, req_type, symbol, end_of_block, primary_index,
                  input ready);
  modport sink   (input valid, req_type, symbol, end_of_block, primary_index,
                  output ready);
endinterface

interface bwtinv_out_if;
  logic                            valid;
  logic                            ready;
  logic [bwtinv_pkg::SYM_W-1:0]    data_byte;
  logic [bwtinv_pkg::POS_W-1:0]    position;
  logic                            final_byte;
  logic [bwtinv_pkg::STAT_W-1:0]   status;

  modport source (output valid, data_byte, position, final_byte, status,
                  input ready);
  modport sink   (input valid, data_byte, position, final_byte, status,
                  output ready);
endinterface

`default_nettype wire

@@ src/bwtinv_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bwtinv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ src/bwtinv_addcmp.sv @@
// Shared add-and-compare unit: sum of two operands and sum >= limit.
// Used for the prefix sum, the LF step and the primary index check.
`default_nettype none

module bwtinv_addcmp #(
  parameter int unsigned W = 14
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire logic [W-1:0] lim,
  output logic      [W-1:0] sum,
  output logic              ge
);

  assign sum = a + b;
  assign ge  = (sum >= lim);

endmodule

`default_nettype wire

@@ src/bwt_inverse_lf_walk.sv @@
// Inverse Burrows-Wheeler transform, one block at a time.
// in_bus (sink): request words. req_type load brings one last-column byte;
//   the load with end_of_block set closes the block and carries primary_index.
//   req_type read fetches the next decoded byte.
// out_bus (source): one result word per final load and per read; plain loads
//   give none. status: ok, no data ready, or primary index out of range.
// Sequence: a plain load reads the count RAM, then writes the stores.
//   A read passes the decoded RAM read, the result stage and the output register.
//   A final load adds the prefix sweep over the 256 symbol counts, the LF walk
//   over the N bytes of the block and the emit state; each walk step is bound by
//   two dependent RAM reads and one pass through the shared adder.
// in_bus.ready is high only while the sequencer is idle. A result sits in the
//   output register until taken; the next word may already be accepted, and
//   the sequencer waits in its emit state only if a second result is ready
//   before the first has left.
// Reset (rst_n, synchronous): sequencer idle, no result pending, symbol count
//   valid bits, block length, read pointer and load count cleared. The byte
//   stores are not cleared; they are only read where written.
// Block start clears all symbol count valid bits at once.
`default_nettype none

module bwt_inverse_lf_walk #(
  parameter int unsigned BLOCK_SIZE = bwtinv_pkg::BLOCK_SIZE_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bwtinv_in_if.sink   in_bus,
  bwtinv_out_if.source out_bus
);

  localparam int unsigned AW   = $clog2(BLOCK_SIZE);
  localparam int unsigned CW   = $clog2(BLOCK_SIZE + 1);
  localparam int unsigned CMPW = (CW > bwtinv_pkg::POS_W) ? CW : bwtinv_pkg::POS_W;
  localparam int unsigned UW   = CMPW + 1;
  localparam int unsigned SW   = bwtinv_pkg::SYM_W;
  localparam int unsigned NSYM = bwtinv_pkg::NSYM;
  localparam int unsigned XW   = bwtinv_pkg::SYM_IDX_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(BLOCK_SIZE);

  bwtinv_pkg::state_t state_r, state_nxt;

  // captured request word
  logic                            req_r, req_nxt;
  logic [SW-1:0]                   sym_r, sym_nxt;
  logic                            eob_r, eob_nxt;
  logic [bwtinv_pkg::PRI_W-1:0]    pri_r, pri_nxt;

  // block control
  logic [CW-1:0]   load_cnt_r, load_cnt_nxt;
  logic [CW-1:0]   blk_len_r, blk_len_nxt;
  logic [CW-1:0]   rp_r, rp_nxt;
  logic            dec_ready_r, dec_ready_nxt;
  logic [NSYM-1:0] cvalid_r, cvalid_nxt;

  // sweep / walk
  logic [XW-1:0]   pfx_idx_r, pfx_idx_nxt;
  logic [CW-1:0]   total_r, total_nxt;
  logic [AW-1:0]   row_r, row_nxt;
  logic [CW-1:0]   walk_cnt_r, walk_cnt_nxt;

  // staged result and output register
  logic [SW-1:0]                 res_data_r, res_data_nxt;
  logic [bwtinv_pkg::POS_W-1:0]  res_pos_r, res_pos_nxt;
  logic                          res_fin_r, res_fin_nxt;
  logic [bwtinv_pkg::STAT_W-1:0] res_stat_r, res_stat_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [SW-1:0]                 out_data_r;
  logic [bwtinv_pkg::POS_W-1:0]  out_pos_r;
  logic                          out_fin_r;
  logic [bwtinv_pkg::STAT_W-1:0] out_stat_r;
  logic                          out_load;

  // RAM ports
  logic            lc_we, lc_re;
  logic [AW-1:0]   lc_waddr, lc_raddr;
  logic [SW-1:0]   lc_rdata;
  logic [AW-1:0]   rk_wdata, rk_rdata;
  logic            cnt_we, cnt_re;
  logic [SW-1:0]   cnt_waddr, cnt_raddr;
  logic [CW-1:0]   cnt_wdata, cnt_rdata;
  logic            st_we, st_re;
  logic [SW-1:0]   st_waddr;
  logic [CW-1:0]   st_rdata;
  logic            dc_we, dc_re;
  logic [AW-1:0]   dc_waddr;
  logic [SW-1:0]   res_data_nxt_ram;

  // shared adder
  logic [UW-1:0]   u_a, u_b, u_lim, u_sum;
  logic            u_ge;

  // helpers
  logic            in_acc;
  logic            full;
  logic [CW-1:0]   cnt_eff;
  logic [CW-1:0]   lc_inc;
  logic [XW-1:0]   pfx_prev9;
  logic [SW-1:0]   pfx_prev;
  logic [CW-1:0]   pfx_cnt;
  logic [CW-1:0]   walk_dec;
  logic [CMPW-1:0] rp_ext;
  logic [CMPW-1:0] pri_ext;
  logic [CW-1:0]   rp_inc;

  assign in_acc    = in_bus.valid && in_bus.ready;
  assign full      = (load_cnt_r == FULL_CNT);
  assign cnt_eff   = cvalid_r[sym_r] ? cnt_rdata : '0;
  assign lc_inc    = full ? load_cnt_r : load_cnt_r + CW'(1);
  assign pfx_prev9 = pfx_idx_r - XW'(1);
  assign pfx_prev  = pfx_prev9[SW-1:0];
  assign pfx_cnt   = cvalid_r[pfx_prev] ? cnt_rdata : '0;
  assign walk_dec  = walk_cnt_r - CW'(1);
  assign rp_ext    = CMPW'(rp_r);
  assign pri_ext   = CMPW'(pri_r);
  assign rp_inc    = rp_r + CW'(1);

  // ---------------- memories ----------------
  // last column byte and its rank share address and enables
  bwtinv_ram #(.WIDTH(SW), .DEPTH(BLOCK_SIZE)) u_last_col (
    .clk, .we(lc_we), .waddr(lc_waddr), .wdata(sym_r),
    .re(lc_re), .raddr(lc_raddr), .rdata(lc_rdata)
  );

  bwtinv_ram #(.WIDTH(AW), .DEPTH(BLOCK_SIZE)) u_rank (
    .clk, .we(lc_we), .waddr(lc_waddr), .wdata(rk_wdata),
    .re(lc_re), .raddr(lc_raddr), .rdata(rk_rdata)
  );

  bwtinv_ram #(.WIDTH(CW), .DEPTH(NSYM)) u_counts (
    .clk, .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .re(cnt_re), .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  bwtinv_ram #(.WIDTH(CW), .DEPTH(NSYM)) u_starts (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(total_r),
    .re(st_re), .raddr(lc_rdata), .rdata(st_rdata)
  );

  bwtinv_ram #(.WIDTH(SW), .DEPTH(BLOCK_SIZE)) u_decoded (
    .clk, .we(dc_we), .waddr(dc_waddr), .wdata(lc_rdata),
    .re(dc_re), .raddr(rp_r[AW-1:0]), .rdata(res_data_nxt_ram)
  );

  bwtinv_addcmp #(.W(UW)) u_addcmp (
    .a(u_a), .b(u_b), .lim(u_lim), .sum(u_sum), .ge(u_ge)
  );

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bwtinv_pkg::S_IDLE;
      load_cnt_r  <= '0;
      blk_len_r   <= '0;
      rp_r        <= '0;
      dec_ready_r <= 1'b0;
      cvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      blk_len_r   <= blk_len_nxt;
      rp_r        <= rp_nxt;
      dec_ready_r <= dec_ready_nxt;
      cvalid_r    <= cvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    sym_r      <= sym_nxt;
    eob_r      <= eob_nxt;
    pri_r      <= pri_nxt;
    pfx_idx_r  <= pfx_idx_nxt;
    total_r    <= total_nxt;
    row_r      <= row_nxt;
    walk_cnt_r <= walk_cnt_nxt;
    res_data_r <= res_data_nxt;
    res_pos_r  <= res_pos_nxt;
    res_fin_r  <= res_fin_nxt;
    res_stat_r <= res_stat_nxt;
    if (out_load) begin
      out_data_r <= res_data_r;
      out_pos_r  <= res_pos_r;
      out_fin_r  <= res_fin_r;
      out_stat_r <= res_stat_r;
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    sym_nxt       = sym_r;
    eob_nxt       = eob_r;
    pri_nxt       = pri_r;
    load_cnt_nxt  = load_cnt_r;
    blk_len_nxt   = blk_len_r;
    rp_nxt        = rp_r;
    dec_ready_nxt = dec_ready_r;
    cvalid_nxt    = cvalid_r;
    pfx_idx_nxt   = pfx_idx_r;
    total_nxt     = total_r;
    row_nxt       = row_r;
    walk_cnt_nxt  = walk_cnt_r;
    res_data_nxt  = res_data_r;
    res_pos_nxt   = res_pos_r;
    res_fin_nxt   = res_fin_r;
    res_stat_nxt  = res_stat_r;
    out_load      = 1'b0;

    lc_we     = 1'b0;
    lc_re     = 1'b0;
    lc_waddr  = load_cnt_r[AW-1:0];
    lc_raddr  = row_r;
    rk_wdata  = cnt_eff[AW-1:0];
    cnt_we    = 1'b0;
    cnt_re    = 1'b0;
    cnt_waddr = sym_r;
    cnt_wdata = cnt_eff + CW'(1);
    cnt_raddr = in_bus.symbol;
    st_we     = 1'b0;
    st_re     = 1'b0;
    st_waddr  = pfx_prev;
    dc_we     = 1'b0;
    dc_re     = 1'b0;
    dc_waddr  = walk_dec[AW-1:0];

    u_a   = '0;
    u_b   = '0;
    u_lim = '0;

    unique case (state_r)
      bwtinv_pkg::S_IDLE: begin
        if (in_acc) begin
          req_nxt = in_bus.req_type;
          sym_nxt = in_bus.symbol;
          eob_nxt = in_bus.end_of_block;
          pri_nxt = in_bus.primary_index;
          if (in_bus.req_type == bwtinv_pkg::REQ_LOAD) begin
            cnt_re = 1'b1;
            if (load_cnt_r == '0) begin
              // block start: drop counts and any block still being read
              cvalid_nxt    = '0;
              dec_ready_nxt = 1'b0;
            end
            state_nxt = bwtinv_pkg::S_LOAD;
          end else if (dec_ready_r && (rp_r < blk_len_r)) begin
            dc_re     = 1'b1;
            state_nxt = bwtinv_pkg::S_RD;
          end else begin
            dec_ready_nxt = 1'b0;
            res_data_nxt  = '0;
            res_pos_nxt   = '0;
            res_fin_nxt   = 1'b0;
            res_stat_nxt  = bwtinv_pkg::STAT_NODATA;
            state_nxt     = bwtinv_pkg::S_EMIT;
          end
        end
      end

      bwtinv_pkg::S_LOAD: begin
        if (!full) begin
          lc_we               = 1'b1;
          cnt_we              = 1'b1;
          cvalid_nxt[sym_r]   = 1'b1;
          load_cnt_nxt        = lc_inc;
        end
        // primary index range check on the shared unit
        u_a   = UW'(pri_r);
        u_lim = UW'(lc_inc);
        if (eob_r) begin
          blk_len_nxt  = lc_inc;
          load_cnt_nxt = '0;
          rp_nxt       = '0;
          if (u_ge) begin
            dec_ready_nxt = 1'b0;
            res_data_nxt  = '0;
            res_pos_nxt   = '0;
            res_fin_nxt   = 1'b0;
            res_stat_nxt  = bwtinv_pkg::STAT_RANGE;
            state_nxt     = bwtinv_pkg::S_EMIT;
          end else begin
            pfx_idx_nxt = '0;
            total_nxt   = '0;
            state_nxt   = bwtinv_pkg::S_PFX;
          end
        end else begin
          state_nxt = bwtinv_pkg::S_IDLE;
        end
      end

      bwtinv_pkg::S_PFX: begin
        // read count of idx while storing start of idx-1
        cnt_raddr = pfx_idx_r[SW-1:0];
        cnt_re    = !pfx_idx_r[XW-1];
        if (pfx_idx_r != '0) begin
          st_we     = 1'b1;
          u_a       = UW'(total_r);
          u_b       = UW'(pfx_cnt);
          u_lim     = '1;
          total_nxt = u_sum[CW-1:0];
        end
        pfx_idx_nxt = pfx_idx_r + XW'(1);
        if (pfx_idx_r[XW-1]) begin
          row_nxt      = pri_ext[AW-1:0];
          walk_cnt_nxt = blk_len_r;
          state_nxt    = bwtinv_pkg::S_WALK_A;
        end
      end

      bwtinv_pkg::S_WALK_A: begin
        lc_re     = 1'b1;
        state_nxt = bwtinv_pkg::S_WALK_B;
      end

      bwtinv_pkg::S_WALK_B: begin
        dc_we     = 1'b1;
        st_re     = 1'b1;
        state_nxt = bwtinv_pkg::S_WALK_C;
      end

      bwtinv_pkg::S_WALK_C: begin
        // LF step: row = start[s] + rank, wrapped to zero past the block
        u_a          = UW'(st_rdata);
        u_b          = UW'(rk_rdata);
        u_lim        = UW'(blk_len_r);
        row_nxt      = u_ge ? '0 : u_sum[AW-1:0];
        walk_cnt_nxt = walk_dec;
        if (walk_cnt_r == CW'(1)) begin
          dec_ready_nxt = 1'b1;
          res_data_nxt  = '0;
          res_pos_nxt   = '0;
          res_fin_nxt   = 1'b0;
          res_stat_nxt  = bwtinv_pkg::STAT_OK;
          state_nxt     = bwtinv_pkg::S_EMIT;
        end else begin
          state_nxt = bwtinv_pkg::S_WALK_A;
        end
      end

      bwtinv_pkg::S_RD: begin
        res_data_nxt = res_data_nxt_ram;
        res_pos_nxt  = rp_ext[bwtinv_pkg::POS_W-1:0];
        res_fin_nxt  = (rp_inc == blk_len_r);
        res_stat_nxt = bwtinv_pkg::STAT_OK;
        rp_nxt       = rp_inc;
        if (rp_inc == blk_len_r) begin
          dec_ready_nxt = 1'b0;
        end
        state_nxt = bwtinv_pkg::S_EMIT;
      end

      bwtinv_pkg::S_EMIT: begin
        if (!out_valid_r || out_bus.ready) begin
          out_load  = 1'b1;
          state_nxt = bwtinv_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bwtinv_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign in_bus.ready       = (state_r == bwtinv_pkg::S_IDLE);
  assign out_bus.valid      = out_valid_r;
  assign out_bus.data_byte  = out_data_r;
  assign out_bus.position   = out_pos_r;
  assign out_bus.final_byte = out_fin_r;
  assign out_bus.status     = out_stat_r;

`ifndef NO_ASSERTIONS
  // a walk step always addresses a row inside the block
  a_row_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bwtinv_pkg::S_WALK_A) |-> (CW'(row_r) < blk_len_r))
    else $error("LF walk row outside block");

  // load count never runs past the store depth
  a_load_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    load_cnt_r <= FULL_CNT)
    else $error("load count overflow");

  // a new result only comes from the emit state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    (!$past(out_valid_r) && out_valid_r) |-> $past(state_r == bwtinv_pkg::S_EMIT))
    else $error("result word without emit");

  // reading the last byte closes the decoded block
  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bwtinv_pkg::S_RD && rp_inc == blk_len_r) |=> !dec_ready_r)
    else $error("decoded_ready held after final byte");

  // read pointer stays within the block
  a_rp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bwtinv_pkg::S_RD) |-> (rp_r < blk_len_r))
    else $error("read pointer past block length");
`endif

endmodule

`default_nettype wire
